// ===== rtl/core/dat_pkg.sv =====
// Shared constants, codes and controller/datapath signal groups of the trie lookup.
package dat_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int VALUE_W     = 16;
  localparam int LIMIT_W     = 13;
  localparam int BYTE_W      = 8;
  localparam int SUM_W       = VALUE_W + 1;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(TABLE_DEPTH);

  // Item operation codes.
  localparam logic [OP_W-1:0] OP_WR_BASE  = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_CHECK = 2'd1;
  localparam logic [OP_W-1:0] OP_KEY_BYTE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_base;     // write base entry from the input beat
    logic wr_check;    // write check entry from the input beat
    logic take_byte;   // capture key byte, read base at the current node
    logic eval_range;  // form target, record a range failure
    logic rd_target;   // read base and check at the target
    logic eval_check;  // compare check entry, advance or record a mismatch
    logic emit;        // load the result register and return to the root
  } dat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic failed;      // the walk has already failed
    logic out_range;   // target at or beyond the entries in use
    logic byte_zero;   // captured key byte is the terminator
    logic out_free;    // result register can take a new result
  } dat_stat_t;

endpackage

// ===== rtl/core/dat_if.sv =====
// Valid/ready channel interfaces for load and key items, results and configuration.
interface dat_item_if;
  logic                           valid;
  logic                           ready;
  logic [dat_pkg::OP_W-1:0]       op;
  logic [dat_pkg::ADDR_W-1:0]     entry_index;
  logic [dat_pkg::VALUE_W-1:0]    entry_value;
  logic [dat_pkg::BYTE_W-1:0]     key_byte;

  modport source (output valid, op, entry_index, entry_value, key_byte, input ready);
  modport sink   (input valid, op, entry_index, entry_value, key_byte, output ready);
endinterface

interface dat_result_if;
  logic                           valid;
  logic                           ready;
  logic [dat_pkg::STATUS_W-1:0]   status;
  logic [dat_pkg::VALUE_W-1:0]    key_id;

  modport source (output valid, status, key_id, input ready);
  modport sink   (input valid, status, key_id, output ready);
endinterface

interface dat_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dat_pkg::LIMIT_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/dat_ctrl.sv =====
// Controller state machine that sequences loads and the per-byte trie walk.
module dat_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  logic [dat_pkg::OP_W-1:0] item_op,
  output logic                    item_ready,
  input  dat_pkg::dat_stat_t      stat,
  output dat_pkg::dat_cmd_t       cmd
);
  import dat_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item_op)
            OP_WR_BASE:  cmd.wr_base  = 1'b1;
            OP_WR_CHECK: cmd.wr_check = 1'b1;
            OP_KEY_BYTE: begin
              cmd.take_byte = 1'b1;
              state_next    = S_STEP;
            end
            default: ;
          endcase
        end
      end
      S_STEP: begin
        cmd.eval_range = 1'b1;
        if (stat.failed || stat.out_range) begin
          state_next = stat.byte_zero ? S_EMIT : S_IDLE;
        end else begin
          cmd.rd_target = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.eval_check = 1'b1;
        state_next     = stat.byte_zero ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/dat_path.sv =====
// Datapath: base and check tables, walk registers, bound register and result register.
module dat_path (
  input  logic                      clk,
  input  logic                      rst,
  input  dat_pkg::dat_cmd_t         cmd,
  output dat_pkg::dat_stat_t        stat,
  input  logic [dat_pkg::ADDR_W-1:0]  entry_index,
  input  logic [dat_pkg::VALUE_W-1:0] entry_value,
  input  logic [dat_pkg::BYTE_W-1:0]  key_byte,
  input  logic                      cfg_write,
  input  logic [dat_pkg::LIMIT_W-1:0] cfg_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [dat_pkg::STATUS_W-1:0] res_status,
  output logic [dat_pkg::VALUE_W-1:0]  res_key_id
);
  import dat_pkg::*;

  logic [VALUE_W-1:0]  base_mem  [TABLE_DEPTH];
  logic [VALUE_W-1:0]  check_mem [TABLE_DEPTH];

  logic [VALUE_W-1:0]  base_q;
  logic [VALUE_W-1:0]  check_q;
  logic [ADDR_W-1:0]   node;
  logic [ADDR_W-1:0]   target;
  logic [STATUS_W-1:0] walk_failed;
  logic [BYTE_W-1:0]   kb;
  logic [LIMIT_W-1:0]  entries_in_use;

  logic [LIMIT_W-1:0]  limit;
  logic [SUM_W-1:0]    sum;
  logic [ADDR_W-1:0]   base_rd_addr;
  logic                base_rd;

  assign limit = (entries_in_use > LIMIT_MAX) ? LIMIT_MAX : entries_in_use;
  assign sum   = {1'b0, base_q} + SUM_W'(kb);

  assign base_rd      = cmd.take_byte || cmd.rd_target;
  assign base_rd_addr = cmd.take_byte ? node : sum[ADDR_W-1:0];

  assign stat.failed    = (walk_failed != ST_FOUND);
  assign stat.out_range = (sum >= SUM_W'(limit));
  assign stat.byte_zero = (kb == '0);
  assign stat.out_free  = !res_valid || res_ready;

  // Table ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (cmd.wr_base) begin
      base_mem[entry_index] <= entry_value;
    end
    if (base_rd) begin
      base_q <= base_mem[base_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_check) begin
      check_mem[entry_index] <= entry_value;
    end
    if (cmd.rd_target) begin
      check_q <= check_mem[sum[ADDR_W-1:0]];
    end
  end

  // Payload registers of the walk.
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      kb <= key_byte;
    end
    if (cmd.rd_target) begin
      target <= sum[ADDR_W-1:0];
    end
    if (cmd.emit) begin
      res_status <= walk_failed;
      res_key_id <= (walk_failed == ST_FOUND) ? base_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node           <= '0;
      walk_failed    <= ST_FOUND;
      res_valid      <= 1'b0;
      entries_in_use <= LIMIT_RESET;
    end else begin
      if (cfg_write) begin
        entries_in_use <= cfg_data;
      end
      if (cmd.eval_range && (walk_failed == ST_FOUND) && stat.out_range) begin
        walk_failed <= ST_RANGE;
      end
      if (cmd.eval_check) begin
        if (check_q != VALUE_W'(node)) begin
          walk_failed <= ST_MISMATCH;
        end else begin
          node <= target;
        end
      end
      if (cmd.emit) begin
        node        <= '0;
        walk_failed <= ST_FOUND;
        res_valid   <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/double_array_trie_lookup.sv =====
// Top level of the double-array trie lookup: controller, datapath and channel wiring.
//
// The block holds a base table and a check table of 4096 sixteen-bit entries each. A
// load beat (op 0 or 1) writes one entry when it is accepted. A key beat (op 2) walks
// the trie by one byte: the cycle that accepts it reads base at the current node, the
// next cycle adds the byte, checks the sum against the entries in use and reads base
// and check at the target, and S_CHECK then compares check with the old node; these
// steps follow from the registered reads of the two table memories. The terminator
// byte is walked like any other and then, in S_EMIT, loads the result register, which
// offers status and key id while the next beat is already being accepted; if an
// earlier result is still waiting, the terminator holds until it has been taken. Once
// a walk has failed, its remaining bytes skip S_CHECK and read only base at the
// current node, never the target entries, and the first failure is reported at the
// terminator. A byte whose target is out of range also skips S_CHECK. The
// entries-in-use register is written through the configuration channel, which is
// always ready, and resets to 4096. The tables are not cleared at reset: each entry
// must be loaded before a walk reads it.
module double_array_trie_lookup (
  input logic          clk,
  input logic          rst,
  dat_item_if.sink     item,
  dat_result_if.source result,
  dat_cfg_if.sink      cfg
);
  import dat_pkg::*;

  dat_cmd_t  cmd;
  dat_stat_t stat;

  assign cfg.ready = 1'b1;

  dat_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_op    (item.op),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dat_path u_path (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .entry_index (item.entry_index),
    .entry_value (item.entry_value),
    .key_byte    (item.key_byte),
    .cfg_write   (cfg.valid && cfg.ready),
    .cfg_data    (cfg.data),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_status  (result.status),
    .res_key_id  (result.key_id)
  );

  // A key beat keeps the block busy for the following cycle.
  a_key_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && (item.op == OP_KEY_BYTE) |=> !item.ready)
    else $error("input accepted straight after a key beat");

  // A failed lookup never carries a key id.
  a_fail_no_id: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status != ST_FOUND) |-> (result.key_id == '0))
    else $error("failure result with a non-zero key id");

  // Issuing a result returns the walk to a clean root.
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !stat.failed && result.valid)
    else $error("walk state not cleared after a result");

  // Table writes only happen while the block is taking a beat.
  a_write_on_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_base || cmd.wr_check) |-> (item.valid && item.ready))
    else $error("table write without an accepted load beat");

endmodule

// ===== tb/sv/trie_lookup_checker.sv =====
`timescale 1ns / 1ps
// Checker that follows the beats of the trie lookup, predicts each result and compares it.
module trie_lookup_checker (
  input  logic  clk,
  input  logic  rst,
  dat_item_if   item,
  dat_result_if result,
  dat_cfg_if    cfg,
  output int    mismatches,
  output int    outstanding
);
  import dat_pkg::*;

  // Results still owed by the block, held in a small ring.
  localparam int EXP_DEPTH = 16;
  localparam int EXP_PTR_W = $clog2(EXP_DEPTH);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  key_id;
  } lookup_t;

  logic [VALUE_W-1:0]   base_copy  [TABLE_DEPTH];
  logic [VALUE_W-1:0]   check_copy [TABLE_DEPTH];
  logic [ADDR_W-1:0]    walk_node;
  logic [STATUS_W-1:0]  walk_status;
  logic [LIMIT_W-1:0]   entries_limit;
  lookup_t              expected_lookups [EXP_DEPTH];
  logic [EXP_PTR_W-1:0] exp_head;
  logic [EXP_PTR_W-1:0] exp_tail;
  int                   exp_count;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    exp_head    = '0;
    exp_tail    = '0;
    exp_count   = 0;
  end

  // One key byte: move the walk, and at the terminator queue the lookup result.
  task automatic walk_byte(input logic [BYTE_W-1:0] kb);
    logic [SUM_W-1:0] target;
    logic [SUM_W-1:0] bound;
    lookup_t          res;
    bound = (entries_limit < LIMIT_MAX) ? SUM_W'(entries_limit) : SUM_W'(LIMIT_MAX);
    if (walk_status == ST_FOUND) begin
      target = SUM_W'(base_copy[walk_node]) + SUM_W'(kb);
      if (target >= bound) begin
        walk_status = ST_RANGE;
      end else if (check_copy[target[ADDR_W-1:0]] != VALUE_W'(walk_node)) begin
        walk_status = ST_MISMATCH;
      end else begin
        walk_node = target[ADDR_W-1:0];
      end
    end
    if (kb == '0) begin
      res.status = walk_status;
      res.key_id = (walk_status == ST_FOUND) ? base_copy[walk_node] : '0;
      if (exp_count >= EXP_DEPTH) begin
        $display("%0t: more results owed than the checker can hold", $time);
        mismatches++;
      end else begin
        expected_lookups[exp_tail] = res;
        exp_tail  = exp_tail + 1'b1;
        exp_count = exp_count + 1;
      end
      walk_node   = '0;
      walk_status = ST_FOUND;
    end
  endtask

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      walk_node     = '0;
      walk_status   = ST_FOUND;
      entries_limit = LIMIT_RESET;
      exp_head      = '0;
      exp_tail      = '0;
      exp_count     = 0;
    end else begin
      // A result always trails its terminator, so it is
      // compared before this edge's input beat is predicted.
      if (result.valid && result.ready) begin
        if (exp_count == 0) begin
          $display("%0t: result beat with nothing expected: status %0d key_id %h",
                   $time, result.status, result.key_id);
          mismatches++;
        end else begin
          want      = expected_lookups[exp_head];
          exp_head  = exp_head + 1'b1;
          exp_count = exp_count - 1;
          if (result.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     result.status);
            mismatches++;
          end
          if (result.key_id !== want.key_id) begin
            $display("%0t: key_id expected %h actual %h", $time, want.key_id,
                     result.key_id);
            mismatches++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        entries_limit = cfg.data;
      end
      if (item.valid && item.ready) begin
        case (item.op)
          OP_WR_BASE:  base_copy[item.entry_index]  = item.entry_value;
          OP_WR_CHECK: check_copy[item.entry_index] = item.entry_value;
          OP_KEY_BYTE: walk_byte(item.key_byte);
          default: ;
        endcase
      end
    end
    outstanding = exp_count;
  end

endmodule

// ===== tb/sv/double_array_trie_lookup_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives load, key and configuration beats into the trie lookup and reports.
module double_array_trie_lookup_tb;
  import dat_pkg::*;

  // The fourth op code is unused by the block; it must be swallowed silently.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Number of beats of random stimulus per configuration phase.
  localparam int PHASE_BEATS = 260;
  localparam int NUM_PHASES  = 7;
  // Cycles for which the receiver refuses results in the back-pressure phase.
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  dat_item_if   item_ch ();
  dat_result_if result_ch ();
  dat_cfg_if    cfg_ch ();

  int mismatches;
  int outstanding;

  double_array_trie_lookup uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  trie_lookup_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Idling controls, set by the stimulus process; the sink stall and pressure controls are read by the receiver.
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  bit pressure_on   = 1'b0;

  // Receiver-side state, written only by the receiver process.
  int hold_count;
  bit hold_done;

  // The stimulus keeps its own picture of the tables so that it can plant keys
  // that really walk through the trie. It plays no part in the checking. An
  // entry that was never loaded stays unknown here.
  logic [VALUE_W-1:0] plan_base  [TABLE_DEPTH];
  logic [VALUE_W-1:0] plan_check [TABLE_DEPTH];
  int                 limit_now;
  logic [BYTE_W-1:0]  key_buf [8];
  int                 beats_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous guard: the slowest legal run is far shorter than this.
  initial begin
    #3_000_000;
    $display("double_array_trie_lookup_tb NOT OK");
    $finish;
  end

  // Receiver: stalls at random, and once in the back-pressure phase it refuses
  // every result for a long stretch so that the block backs up onto its input.
  initial begin
    result_ch.ready = 1'b0;
    hold_count      = 0;
    hold_done       = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_on && !hold_done) begin
        result_ch.ready <= 1'b0;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) begin
          hold_done = 1'b1;
        end
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // The bound that the block applies: the register, clipped at the table depth.
  function automatic int bound_now();
    return (limit_now < TABLE_DEPTH) ? limit_now : TABLE_DEPTH;
  endfunction

  // Base values are mostly chosen so that every byte from the node stays inside
  // the entries in use; now and then a full-width value forces an overflow.
  function automatic logic [VALUE_W-1:0] pick_base();
    int b;
    b = bound_now();
    if ($urandom_range(19) == 0) begin
      return VALUE_W'($urandom_range(65535));
    end else if (b > 256) begin
      return VALUE_W'($urandom_range(b - 256));
    end else begin
      return VALUE_W'($urandom_range(b));
    end
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and wait until it has
  // been accepted. Called and left at a falling edge.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] idx,
                           input logic [VALUE_W-1:0] val, input logic [BYTE_W-1:0] kb);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.op          <= op;
    item_ch.entry_index <= idx;
    item_ch.entry_value <= val;
    item_ch.key_byte    <= kb;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    if (op == OP_WR_BASE) begin
      plan_base[idx] = val;
    end else if (op == OP_WR_CHECK) begin
      plan_check[idx] = val;
    end
    if (op != OP_UNUSED) begin
      beats_sent++;
    end
  endtask

  // Load beats carry a random key byte, key beats a random index and value, so
  // that the fields the block ignores are exercised too.
  task automatic load_entry(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] idx,
                            input logic [VALUE_W-1:0] val);
    send_beat(op, idx, val, BYTE_W'($urandom_range(255)));
  endtask

  task automatic key_beat(input logic [BYTE_W-1:0] kb);
    send_beat(OP_KEY_BYTE, ADDR_W'($urandom_range(TABLE_DEPTH - 1)),
              VALUE_W'($urandom_range(65535)), kb);
  endtask

  // Write the check and base entries that make the key in key_buf[0..len] walk
  // successfully, as far as the entries in use allow. The root base is loaded
  // first if it was never written or leaves no room for a byte.
  task automatic plant_key(input int len);
    logic [ADDR_W-1:0] node;
    logic [SUM_W-1:0]  target;
    node = '0;
    if ($isunknown(plan_base[0]) || (int'(plan_base[0]) + 255 >= bound_now())) begin
      load_entry(OP_WR_BASE, '0, pick_base());
    end
    for (int i = 0; i <= len; i++) begin
      target = SUM_W'(plan_base[node]) + SUM_W'(key_buf[i]);
      if (int'(target) >= bound_now()) begin
        break;
      end
      load_entry(OP_WR_CHECK, target[ADDR_W-1:0], VALUE_W'(node));
      load_entry(OP_WR_BASE, target[ADDR_W-1:0],
                 (i < len) ? pick_base() : VALUE_W'($urandom_range(65535)));
      node = target[ADDR_W-1:0];
    end
  endtask

  // Follow the bytes in key_buf[0..len] through the planned tables and load
  // every entry that the walk will read but that was never written, so that no
  // lookup ever touches an undefined entry.
  task automatic prepare_walk(input int len);
    logic [ADDR_W-1:0] node;
    logic [SUM_W-1:0]  target;
    bit                failed;
    node   = '0;
    failed = 1'b0;
    for (int i = 0; i <= len; i++) begin
      if (!failed) begin
        if ($isunknown(plan_base[node])) begin
          load_entry(OP_WR_BASE, node, pick_base());
        end
        target = SUM_W'(plan_base[node]) + SUM_W'(key_buf[i]);
        if (int'(target) >= bound_now()) begin
          failed = 1'b1;
        end else begin
          if ($isunknown(plan_check[target[ADDR_W-1:0]])) begin
            load_entry(OP_WR_CHECK, target[ADDR_W-1:0], VALUE_W'($urandom_range(65535)));
          end
          if (plan_check[target[ADDR_W-1:0]] != VALUE_W'(node)) begin
            failed = 1'b1;
          end else begin
            node = target[ADDR_W-1:0];
            if ($isunknown(plan_base[node])) begin
              load_entry(OP_WR_BASE, node, pick_base());
            end
          end
        end
      end
      if (key_buf[i] == '0) begin
        node   = '0;
        failed = 1'b0;
      end
    end
  endtask

  task automatic walk_key(input int len);
    prepare_walk(len);
    for (int i = 0; i <= len; i++) begin
      key_beat(key_buf[i]);
    end
  endtask

  // A key of len non-zero bytes followed by the terminator.
  task automatic fill_key(input int len);
    for (int i = 0; i < len; i++) begin
      key_buf[i] = BYTE_W'($urandom_range(1, 255));
    end
    key_buf[len] = '0;
  endtask

  task automatic write_limit(input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= LIMIT_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    limit_now = value;
  endtask

  // Wait until every expected result has come, then give a trailing load or
  // key byte, which yields no result, time to finish inside the block.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (12) @(negedge clk);
  endtask

  initial begin
    int phase_limits [NUM_PHASES];
    int goal;
    int sel;
    int len;
    int pos;

    phase_limits = '{4096, 8191, 1, 0, 300, 4095, 0};

    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.op          = OP_WR_BASE;
    item_ch.entry_index = '0;
    item_ch.entry_value = '0;
    item_ch.key_byte    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    limit_now           = int'(LIMIT_RESET);
    beats_sent          = 0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats under the reset bound. First a one-byte key, then one
    // whose byte is the largest value, then the empty key.
    key_buf[0] = 8'h41;
    key_buf[1] = '0;
    plant_key(1);
    walk_key(1);
    key_buf[0] = 8'hFF;
    key_buf[1] = '0;
    plant_key(1);
    walk_key(1);
    key_buf[0] = '0;
    plant_key(0);
    walk_key(0);

    // A root base at its largest value: the sum must not wrap, so the walk is
    // out of range, and the bytes after the failure are passed over.
    load_entry(OP_WR_BASE, '0, 16'hFFFF);
    key_beat(8'h80);
    key_beat(8'h01);
    key_beat(8'h00);

    // A check entry that names another parent gives a mismatch, which is the
    // status kept even though later bytes follow.
    load_entry(OP_WR_BASE, '0, 16'd10);
    load_entry(OP_WR_CHECK, 12'd15, 16'd7);
    key_beat(8'd5);
    key_beat(8'd3);
    key_beat(8'd0);

    // The unused op code must change nothing and produce nothing.
    send_beat(OP_UNUSED, ADDR_W'($urandom_range(TABLE_DEPTH - 1)),
              VALUE_W'($urandom_range(65535)), 8'h00);

    // Random phases. Each one rewrites the bound while the block is idle and
    // picks its own idling pattern; one of them adds the long receiver hold.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == NUM_PHASES - 1) begin
        phase_limits[ph] = $urandom_range(1, 4096);
      end
      write_limit(phase_limits[ph]);
      case (ph % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 64;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 64;
        end
        default: begin
          src_idle_pct  = 26;
          snk_stall_pct = 26;
        end
      endcase
      pressure_on = (ph == 4);

      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          // A well-formed key planted in the tables, sometimes with one byte
          // spoilt afterwards so that the walk goes astray part way through.
          len = $urandom_range(0, 5);
          fill_key(len);
          plant_key(len);
          if ($urandom_range(99) < 15) begin
            pos = $urandom_range(0, len);
            key_buf[pos] = BYTE_W'($urandom_range(255));
          end
          walk_key(len);
        end else if (sel < 85) begin
          // Noise: arbitrary bytes, zeros included, so keys may end early.
          len = $urandom_range(0, 6);
          for (int i = 0; i < len; i++) begin
            key_buf[i] = BYTE_W'($urandom_range(255));
          end
          key_buf[len] = '0;
          walk_key(len);
        end else if (sel < 95) begin
          load_entry($urandom_range(1) ? OP_WR_CHECK : OP_WR_BASE,
                     ADDR_W'($urandom_range(TABLE_DEPTH - 1)),
                     VALUE_W'($urandom_range(65535)));
        end else begin
          send_beat(OP_UNUSED, ADDR_W'($urandom_range(TABLE_DEPTH - 1)),
                    VALUE_W'($urandom_range(65535)), BYTE_W'($urandom_range(255)));
        end
      end
    end

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    pressure_on   = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("double_array_trie_lookup_tb OK");
    end else begin
      $display("double_array_trie_lookup_tb NOT OK");
    end
    $finish;
  end

endmodule
